@@ rtl/anag_pkg.sv @@
package anag_pkg;

    localparam int ALPHABET_SIZE_DEF = 96;
    localparam int MAX_LEN_DEF       = 1024;
    localparam int CHAR_BASE         = 32;

    typedef enum logic [1:0] {
        CMD_FIRST  = 2'd0,
        CMD_SECOND = 2'd1,
        CMD_END    = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_e;

    typedef enum logic [1:0] {
        STAT_ANAGRAM = 2'd0,
        STAT_LETTER  = 2'd1,
        STAT_LENGTH  = 2'd2,
        STAT_BAD     = 2'd3
    } status_e;

    // write side control of the count memory
    typedef struct packed {
        logic wr;
        logic clr;
    } mem_op_t;

endpackage

@@ rtl/anagram_check_by_histogram.sv @@
// channel   signals                         fields
// item      item_valid / item_stall         cmd[1:0], ch[7:0]
// verdict   verdict_valid / verdict_stall   is_anagram, status[1:0]
//
// one item per cycle unless item_stall; an item reads its count at acceptance and
// writes it back in the next cycle from the count memory's single write port, with
// forwarding of the last write or clear. a verdict registers when its end item commits.
// reset clears the valid bits of the count memory at once, so no clearing pass.
// item_stall rises only while an end item waits for a held verdict register.
module anagram_check_by_histogram
    import anag_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
    parameter int MAX_LEN       = MAX_LEN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [1:0] cmd,
    input  logic [7:0] ch,
    output logic       verdict_valid,
    input  logic       verdict_stall,
    output logic       is_anagram,
    output logic [1:0] status
);

    localparam int SLOT_W = $clog2(ALPHABET_SIZE);
    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);

    // stage 0: decode
    logic [8:0]        ch_off;
    logic              ch_good;
    logic [SLOT_W-1:0] slot;
    logic              accept;
    logic              rd_en;

    // stage 1 registers
    logic              s1_valid_reg, s1_valid_next;
    cmd_e              s1_cmd_reg;
    logic              s1_good_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic              s1_go;
    logic              commit;

    logic [LEN_W-1:0]  first_len_reg, first_len_next;
    logic [LEN_W-1:0]  second_len_reg, second_len_next;
    logic              mismatch_reg, mismatch_next;
    logic              bad_reg, bad_next;

    // last write to the count memory, for forwarding
    logic              wb_wr_reg, wb_wr_next;
    logic              wb_clr_reg, wb_clr_next;
    logic [SLOT_W-1:0] wb_slot_reg;
    logic [LEN_W-1:0]  wb_data_reg;

    logic              out_valid_reg, out_valid_next;
    logic              is_anagram_reg, is_anagram_next;
    logic [1:0]        status_reg, status_next;

    logic [LEN_W-1:0]  rd_data;
    logic [LEN_W-1:0]  cur;
    mem_op_t           op;
    logic [LEN_W-1:0]  wr_data;
    status_e           verdict;

    assign ch_off  = {1'b0, ch} - 9'(CHAR_BASE);
    assign ch_good = (ch >= 8'(CHAR_BASE)) && (ch_off < 9'(ALPHABET_SIZE));
    assign slot    = ch_off[SLOT_W-1:0];

    assign s1_go      = !(s1_cmd_reg == CMD_END && out_valid_reg && verdict_stall);
    assign item_stall = s1_valid_reg && !s1_go;
    assign accept     = item_valid && !item_stall;
    assign commit     = s1_valid_reg && s1_go;
    assign rd_en      = accept && ch_good
                        && (cmd == 2'(CMD_FIRST) || cmd == 2'(CMD_SECOND));

    anag_count_mem #(
        .DEPTH  (ALPHABET_SIZE),
        .DATA_W (LEN_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (slot),
        .rd_data (rd_data),
        .op      (op),
        .wr_addr (s1_slot_reg),
        .wr_data (wr_data)
    );

    always_comb
    begin
        if (wb_clr_reg)
        begin
            cur = '0;
        end
        else if (wb_wr_reg && wb_slot_reg == s1_slot_reg)
        begin
            cur = wb_data_reg;
        end
        else
        begin
            cur = rd_data;
        end
    end

    always_comb
    begin
        if (bad_reg)
        begin
            verdict = STAT_BAD;
        end
        else if (first_len_reg != second_len_reg)
        begin
            verdict = STAT_LENGTH;
        end
        else if (mismatch_reg)
        begin
            verdict = STAT_LETTER;
        end
        else
        begin
            verdict = STAT_ANAGRAM;
        end
    end

    always_comb
    begin
        s1_valid_next   = accept ? 1'b1 : (s1_valid_reg && !s1_go);
        first_len_next  = first_len_reg;
        second_len_next = second_len_reg;
        mismatch_next   = mismatch_reg;
        bad_next        = bad_reg;
        op              = '0;
        wr_data         = cur;
        is_anagram_next = is_anagram_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && verdict_stall;
        if (commit)
        begin
            case (s1_cmd_reg)
                CMD_FIRST:
                begin
                    if (!s1_good_reg || first_len_reg >= LEN_MAX)
                    begin
                        bad_next = 1'b1;
                    end
                    else
                    begin
                        first_len_next = first_len_reg + 1'b1;
                        op.wr          = 1'b1;
                        wr_data        = cur + 1'b1;
                    end
                end
                CMD_SECOND:
                begin
                    if (!s1_good_reg || second_len_reg >= LEN_MAX)
                    begin
                        bad_next = 1'b1;
                    end
                    else
                    begin
                        second_len_next = second_len_reg + 1'b1;
                        if (cur == '0)
                        begin
                            mismatch_next = 1'b1;
                        end
                        else
                        begin
                            op.wr   = 1'b1;
                            wr_data = cur - 1'b1;
                        end
                    end
                end
                CMD_END:
                begin
                    out_valid_next  = 1'b1;
                    status_next     = verdict;
                    is_anagram_next = (verdict == STAT_ANAGRAM);
                    first_len_next  = '0;
                    second_len_next = '0;
                    mismatch_next   = 1'b0;
                    bad_next        = 1'b0;
                    op.clr          = 1'b1;
                end
                default:
                begin
                    op = '0;
                end
            endcase
        end
        wb_wr_next  = op.wr ? 1'b1 : (op.clr ? 1'b0 : wb_wr_reg);
        wb_clr_next = op.clr ? 1'b1 : (op.wr ? 1'b0 : wb_clr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            first_len_reg  <= '0;
            second_len_reg <= '0;
            mismatch_reg   <= 1'b0;
            bad_reg        <= 1'b0;
            wb_wr_reg      <= 1'b0;
            wb_clr_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            first_len_reg  <= first_len_next;
            second_len_reg <= second_len_next;
            mismatch_reg   <= mismatch_next;
            bad_reg        <= bad_next;
            wb_wr_reg      <= wb_wr_next;
            wb_clr_reg     <= wb_clr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg  <= cmd_e'(cmd);
            s1_good_reg <= ch_good;
            s1_slot_reg <= slot;
        end
        if (op.wr)
        begin
            wb_slot_reg <= s1_slot_reg;
            wb_data_reg <= wr_data;
        end
        is_anagram_reg <= is_anagram_next;
        status_reg     <= status_next;
    end

    assign verdict_valid = out_valid_reg;
    assign is_anagram    = is_anagram_reg;
    assign status        = status_reg;

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (verdict_valid && verdict_stall && s1_cmd_reg == CMD_END))
        else $error("item stall without a held verdict");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && s1_cmd_reg == CMD_END) |=>
        (verdict_valid && first_len_reg == '0 && second_len_reg == '0
         && !bad_reg && !mismatch_reg && wb_clr_reg))
        else $error("end transaction did not clear state");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (first_len_reg <= LEN_MAX) && (second_len_reg <= LEN_MAX))
        else $error("string length beyond limit");

    a_wb_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(wb_wr_reg && wb_clr_reg))
        else $error("forwarding holds both a write and a clear");

    a_verdict_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (verdict_valid && verdict_stall) |=> (verdict_valid && $stable(status)))
        else $error("held verdict changed");

endmodule

@@ rtl/anag_count_mem.sv @@
module anag_count_mem
    import anag_pkg::*;
#(
    parameter int DEPTH  = ALPHABET_SIZE_DEF,
    parameter int DATA_W = $clog2(MAX_LEN_DEF + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data,
    input  mem_op_t                  op,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  vld_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic              rd_live_reg;

    always_ff @(posedge clk)
    begin
        if (op.wr)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // an entry never written since the last clear reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            rd_live_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_live_reg <= vld_reg[rd_addr];
            end
            if (op.clr)
            begin
                vld_reg <= '0;
            end
            else if (op.wr)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_live_reg ? rd_data_reg : '0;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top
    import anag_pkg::*;
();

    localparam int NUM_SLOTS    = ALPHABET_SIZE_DEF;
    localparam int STRING_MAX   = MAX_LEN_DEF;
    localparam int RANDOM_ITEMS = 550;
    localparam int NUM_DIRECTED = 25;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic    is_anagram;
        status_e status;
    } verdict_t;

    typedef struct {
        cmd_e       cmd;
        logic [7:0] ch;
        bit         typed;
        verdict_t   verdict;
    } directed_row_t;

    typedef logic [7:0] char_q_t [$];

    localparam verdict_t V_NONE    = '{1'b0, STAT_ANAGRAM};
    localparam verdict_t V_ANAGRAM = '{1'b1, STAT_ANAGRAM};
    localparam verdict_t V_LETTER  = '{1'b0, STAT_LETTER};
    localparam verdict_t V_LENGTH  = '{1'b0, STAT_LENGTH};
    localparam verdict_t V_BAD     = '{1'b0, STAT_BAD};

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       item_valid    = 1'b0;
    logic       item_stall;
    logic [1:0] cmd           = CMD_NOP;
    logic [7:0] ch            = 8'h00;
    logic       verdict_valid;
    logic       verdict_stall = 1'b0;
    logic       is_anagram;
    logic [1:0] status;

    anagram_check_by_histogram u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .cmd           (cmd),
        .ch            (ch),
        .verdict_valid (verdict_valid),
        .verdict_stall (verdict_stall),
        .is_anagram    (is_anagram),
        .status        (status)
    );

    always #5 clk = ~clk;

    // histogram predictor state
    logic [10:0] tally [NUM_SLOTS];
    logic [10:0] first_len;
    logic [10:0] second_len;
    logic        letter_miss;
    logic        bad_seen;

    verdict_t pending_verdicts [$];
    int       verdict_errors = 0;
    int       items_sent     = 0;
    bit       no_idle        = 1'b0;
    int       stall_left     = 0;
    bit       stall_phase    = 1'b0;

    directed_row_t directed_rows [NUM_DIRECTED] = '{
        '{CMD_END,    8'hff, 1'b1, V_ANAGRAM},
        '{CMD_FIRST,  8'h61, 1'b0, V_NONE},
        '{CMD_SECOND, 8'h61, 1'b0, V_NONE},
        '{CMD_END,    8'h00, 1'b1, V_ANAGRAM},
        // lowest and highest accepted characters
        '{CMD_FIRST,  8'h20, 1'b0, V_NONE},
        '{CMD_FIRST,  8'h7f, 1'b0, V_NONE},
        '{CMD_SECOND, 8'h7f, 1'b0, V_NONE},
        '{CMD_SECOND, 8'h20, 1'b0, V_NONE},
        '{CMD_END,    8'h55, 1'b1, V_ANAGRAM},
        '{CMD_FIRST,  8'h1f, 1'b0, V_NONE},
        '{CMD_END,    8'haa, 1'b1, V_BAD},
        '{CMD_SECOND, 8'hff, 1'b0, V_NONE},
        '{CMD_END,    8'h00, 1'b1, V_BAD},
        // length mismatch wins over letter mismatch
        '{CMD_FIRST,  8'h61, 1'b0, V_NONE},
        '{CMD_FIRST,  8'h62, 1'b0, V_NONE},
        '{CMD_SECOND, 8'h63, 1'b0, V_NONE},
        '{CMD_END,    8'h00, 1'b1, V_LENGTH},
        // second string char ahead of its first string match
        '{CMD_SECOND, 8'h63, 1'b0, V_NONE},
        '{CMD_FIRST,  8'h63, 1'b0, V_NONE},
        '{CMD_END,    8'h00, 1'b1, V_LETTER},
        '{CMD_NOP,    8'h41, 1'b0, V_NONE},
        '{CMD_END,    8'h00, 1'b1, V_ANAGRAM},
        // bad input wins over everything
        '{CMD_SECOND, 8'h7a, 1'b0, V_NONE},
        '{CMD_FIRST,  8'h00, 1'b0, V_NONE},
        '{CMD_END,    8'hff, 1'b1, V_BAD}
    };

    task automatic tally_clear();
        foreach (tally[i])
            tally[i] = '0;
        first_len   = '0;
        second_len  = '0;
        letter_miss = 1'b0;
        bad_seen    = 1'b0;
    endtask

    task automatic tally_item(input cmd_e c, input logic [7:0] chr, output bit gives,
                              output verdict_t v);
        int slot;
        gives = 1'b0;
        v     = V_NONE;
        slot  = int'(chr) - CHAR_BASE;
        case (c)
            CMD_FIRST, CMD_SECOND:
            begin
                if (slot < 0 || slot >= NUM_SLOTS)
                    bad_seen = 1'b1;
                else if (c == CMD_FIRST)
                begin
                    if (first_len >= STRING_MAX)
                        bad_seen = 1'b1;
                    else
                    begin
                        first_len++;
                        tally[slot]++;
                    end
                end
                else
                begin
                    if (second_len >= STRING_MAX)
                        bad_seen = 1'b1;
                    else
                    begin
                        second_len++;
                        if (tally[slot] == 0)
                            letter_miss = 1'b1;
                        else
                            tally[slot]--;
                    end
                end
            end
            CMD_END:
            begin
                if (bad_seen)
                    v.status = STAT_BAD;
                else if (first_len != second_len)
                    v.status = STAT_LENGTH;
                else if (letter_miss)
                    v.status = STAT_LETTER;
                else
                    v.status = STAT_ANAGRAM;
                v.is_anagram = (v.status == STAT_ANAGRAM);
                gives = 1'b1;
                tally_clear();
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // pool 0 repeats a few letters, pool 1 is any char in the accepted range
    function automatic logic [7:0] pick_char(input int pool);
        if (pool == 0)
            return 8'($urandom_range(97, 100));
        return 8'($urandom_range(32, 127));
    endfunction

    function automatic char_q_t shuffled(input char_q_t src);
        char_q_t    dst;
        int         j;
        logic [7:0] tmp;
        dst = src;
        for (int i = dst.size() - 1; i > 0; i--)
        begin
            j      = $urandom_range(0, i);
            tmp    = dst[i];
            dst[i] = dst[j];
            dst[j] = tmp;
        end
        return dst;
    endfunction

    task automatic send_item(input cmd_e c, input logic [7:0] chr, input bit typed,
                             input verdict_t typed_v);
        int       gap;
        bit       gives;
        verdict_t v;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        cmd        <= c;
        ch         <= chr;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        tally_item(c, chr, gives, v);
        if (gives)
            pending_verdicts.push_back(typed ? typed_v : v);
        if (c != CMD_NOP)
            items_sent++;
    endtask

    task automatic hold_until_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // overlong: first string one char past the max length and no second string;
    // otherwise a short random set
    task automatic send_string_pair(input bit overlong);
        char_q_t    word;
        char_q_t    other;
        int         kind;
        int         len;
        int         pool;
        int         pos;
        int         n1;
        int         n2;
        logic [7:0] tmp;
        kind = overlong ? 0 : $urandom_range(0, 99);
        pool = $urandom_range(0, 1);
        if (overlong)
            len = STRING_MAX + 1;
        else if ($urandom_range(0, 9) == 0)
            len = $urandom_range(9, 40);
        else
            len = $urandom_range(0, 8);
        for (int i = 0; i < len; i++)
            word.push_back(pick_char(pool));
        if (!overlong)
            other = shuffled(word);

        if (kind >= 55 && kind < 70)
        begin
            // near miss: one char swapped, dropped or added
            case ($urandom_range(0, 2))
                0:
                begin
                    if (other.size() > 0)
                        other[$urandom_range(0, other.size() - 1)] = pick_char(pool);
                end
                1:
                begin
                    if (other.size() > 0)
                        void'(other.pop_back());
                end
                default:
                    other.push_back(pick_char(pool));
            endcase
        end
        else if (kind >= 82 && kind < 92)
        begin
            tmp = $urandom_range(0, 1) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(128, 255));
            if ($urandom_range(0, 1))
            begin
                pos = $urandom_range(0, word.size());
                word.insert(pos, tmp);
            end
            else
            begin
                pos = $urandom_range(0, other.size());
                other.insert(pos, tmp);
            end
        end

        if (kind >= 92)
        begin
            n1 = $urandom_range(1, 10);
            for (int i = 0; i < n1; i++)
                send_item(cmd_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0, V_NONE);
        end
        else if (kind >= 70 && kind < 82)
        begin
            // interleaved first and second string chars
            n1 = 0;
            n2 = 0;
            while (n1 < word.size() || n2 < other.size())
            begin
                if (n2 >= other.size() || (n1 < word.size() && $urandom_range(0, 1)))
                begin
                    send_item(CMD_FIRST, word[n1], 1'b0, V_NONE);
                    n1++;
                end
                else
                begin
                    send_item(CMD_SECOND, other[n2], 1'b0, V_NONE);
                    n2++;
                end
            end
        end
        else
        begin
            foreach (word[i])
                send_item(CMD_FIRST, word[i], 1'b0, V_NONE);
            foreach (other[i])
                send_item(CMD_SECOND, other[i], 1'b0, V_NONE);
        end
        send_item(CMD_END, 8'($urandom_range(0, 255)), 1'b0, V_NONE);
    endtask

    task automatic note_mismatch(input string what, input verdict_t exp, input verdict_t got);
        verdict_errors++;
        if (verdict_errors <= MAX_REPORTS)
            $display("%0t %s: expected is_anagram=%0b status=%0d, got is_anagram=%0b status=%0d",
                     $realtime, what, exp.is_anagram, exp.status, got.is_anagram, got.status);
    endtask

    // verdict checker and receiver stall pattern
    always @(posedge clk)
    begin
        verdict_t got;
        verdict_t exp;
        if (rst_n && verdict_valid && !verdict_stall)
        begin
            got.is_anagram = is_anagram;
            got.status     = status_e'(status);
            if (pending_verdicts.size() == 0)
                note_mismatch("unexpected verdict transaction", V_NONE, got);
            else
            begin
                exp = pending_verdicts.pop_front();
                if (got.is_anagram !== exp.is_anagram || got.status !== exp.status)
                    note_mismatch("verdict mismatch", exp, got);
            end
        end
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else
        begin
            stall_phase <= ~stall_phase;
            stall_left  <= stall_phase ? $urandom_range(0, 12) : pick_gap();
        end
        verdict_stall <= no_idle ? 1'b0 : (stall_left > 0 && stall_phase);
    end

    initial
    begin
        int set_count;
        tally_clear();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].cmd, directed_rows[i].ch, directed_rows[i].typed,
                      directed_rows[i].verdict);
        hold_until_drained();

        items_sent = 0;
        set_count  = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            set_count++;
            // four of every sixteen sets run without any idling
            no_idle = (set_count % 16) >= 12;
            if (set_count % 37 == 0)
                hold_until_drained();
            send_string_pair(1'b0);
        end

        no_idle = 1'b0;
        hold_until_drained();
        send_string_pair(1'b1);

        hold_until_drained();
        repeat (20) @(posedge clk);
        if (verdict_errors == 0 && pending_verdicts.size() == 0)
            $display("anagram_check_by_histogram regression: pass");
        else
            $display("anagram_check_by_histogram regression: fail");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("anagram_check_by_histogram regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/anag_pkg.sv
rtl/anag_count_mem.sv
rtl/anagram_check_by_histogram.sv
bench/tb_top.sv
